// ===== rtl/rtip_pkg.sv =====
`default_nettype none
package rtip_pkg;

  localparam int MAX_CHARS = 4096;
  localparam int POS_W     = $clog2(MAX_CHARS);
  localparam int OFFSET_W  = 12;
  localparam int VALUE_W   = 64;
  localparam int CH_W      = 8;
  localparam int RADIX_W   = 6;
  localparam int DIGIT_W   = 7;

  localparam logic [POS_W-1:0]   POS_MAX   = POS_W'(MAX_CHARS - 1);
  localparam logic [DIGIT_W-1:0] DIGIT_BAD = 7'd64;

  localparam logic [RADIX_W-1:0] BASE_AUTO = 6'd0;
  localparam logic [RADIX_W-1:0] BASE_OCT  = 6'd8;
  localparam logic [RADIX_W-1:0] BASE_DEC  = 6'd10;
  localparam logic [RADIX_W-1:0] BASE_HEX  = 6'd16;

  localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CH_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CH_W-1:0] CH_0     = 8'h30;
  localparam logic [CH_W-1:0] CH_9     = 8'h39;
  localparam logic [CH_W-1:0] CH_UA    = 8'h41;
  localparam logic [CH_W-1:0] CH_UX    = 8'h58;
  localparam logic [CH_W-1:0] CH_UZ    = 8'h5A;
  localparam logic [CH_W-1:0] CH_LA    = 8'h61;
  localparam logic [CH_W-1:0] CH_LX    = 8'h78;
  localparam logic [CH_W-1:0] CH_LZ    = 8'h7A;
  localparam logic [CH_W-1:0] LETTER_OFS = 8'd10;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_LEAD   = 3'd1,
    PH_START  = 3'd2,
    PH_ZERO   = 3'd3,
    PH_DIGITS = 3'd4
  } rtip_phase_t;

  typedef struct packed {
    rtip_phase_t          phase;
    logic [VALUE_W-1:0]   acc;
    logic                 neg;
    logic [RADIX_W-1:0]   base;
    logic [POS_W-1:0]     pos;
    logic                 any;
  } rtip_state_t;

  typedef struct packed {
    logic                      valid;
    logic signed [VALUE_W-1:0] value;
    logic [OFFSET_W-1:0]       end_offset;
    logic                      digits_found;
  } rtip_res_t;

  function automatic logic is_space(input logic [CH_W-1:0] c);
    return (c == CH_SPACE) || (c inside {[CH_TAB:CH_CR]});
  endfunction

  function automatic logic [DIGIT_W-1:0] digit_of(input logic [CH_W-1:0] c);
    logic [DIGIT_W-1:0] d;
    d = DIGIT_BAD;
    if (c inside {[CH_0:CH_9]}) begin
      d = DIGIT_W'(c - CH_0);
    end else if (c inside {[CH_LA:CH_LZ]}) begin
      d = DIGIT_W'(c - CH_LA + LETTER_OFS);
    end else if (c inside {[CH_UA:CH_UZ]}) begin
      d = DIGIT_W'(c - CH_UA + LETTER_OFS);
    end
    return d;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/rtip_in_if.sv =====
`default_nettype none
interface rtip_in_if;
  import rtip_pkg::*;

  logic               valid;
  logic               ready;
  logic [CH_W-1:0]    ch;
  logic               first;
  logic [RADIX_W-1:0] radix;

  modport source (output valid, output ch, output first, output radix, input ready);
  modport sink   (input valid, input ch, input first, input radix, output ready);
endinterface
`default_nettype wire

// ===== rtl/rtip_out_if.sv =====
`default_nettype none
interface rtip_out_if;
  import rtip_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;
  logic [OFFSET_W-1:0]       end_offset;
  logic                      digits_found;

  modport source (output valid, output value, output end_offset, output digits_found,
                  input ready);
  modport sink   (input valid, input value, input end_offset, input digits_found,
                  output ready);
endinterface
`default_nettype wire

// ===== rtl/rtip_step.sv =====
`default_nettype none
module rtip_step (
  input  rtip_pkg::rtip_state_t         state_i,
  input  logic [rtip_pkg::CH_W-1:0]     ch_i,
  input  logic                          first_i,
  input  logic [rtip_pkg::RADIX_W-1:0]  radix_i,
  output rtip_pkg::rtip_state_t         state_o,
  output rtip_pkg::rtip_res_t           res_o
);
  import rtip_pkg::*;

  always_comb begin
    rtip_state_t               st;
    logic [RADIX_W-1:0]        base_d;
    logic [VALUE_W-1:0]        acc_d;
    logic                      any_d;
    logic                      do_start;
    logic                      do_zero;
    logic                      go_digit;
    logic [DIGIT_W-1:0]        d;
    logic [POS_W+OFFSET_W-1:0] pos_ext;

    st = state_i;
    if (first_i) begin
      st.phase = PH_LEAD;
      st.acc   = '0;
      st.neg   = 1'b0;
      st.base  = radix_i;
      st.pos   = '0;
      st.any   = 1'b0;
    end

    state_o  = st;
    res_o    = '0;
    base_d   = st.base;
    acc_d    = st.acc;
    any_d    = st.any;
    do_start = 1'b0;
    do_zero  = 1'b0;
    go_digit = 1'b0;
    d        = digit_of(ch_i);
    pos_ext  = {{OFFSET_W{1'b0}}, st.pos};

    if (st.phase != PH_IDLE && st.pos < POS_MAX) begin
      state_o.pos = st.pos + 1'b1;
    end

    case (st.phase)
      PH_LEAD: begin
        if (!is_space(ch_i)) begin
          if (ch_i == CH_PLUS || ch_i == CH_MINUS) begin
            state_o.neg   = (ch_i == CH_MINUS);
            state_o.phase = PH_START;
          end else begin
            do_start = 1'b1;
          end
        end
      end
      PH_START:  do_start = 1'b1;
      PH_ZERO:   do_zero  = 1'b1;
      PH_DIGITS: go_digit = 1'b1;
      default:   ;
    endcase

    if (do_start) begin
      if (ch_i == CH_0 && (st.base == BASE_AUTO || st.base == BASE_HEX)) begin
        state_o.phase = PH_ZERO;
      end else begin
        base_d   = (st.base == BASE_AUTO) ? BASE_DEC : st.base;
        go_digit = 1'b1;
      end
    end

    if (do_zero) begin
      if (ch_i == CH_LX || ch_i == CH_UX) begin
        state_o.base  = BASE_HEX;
        state_o.phase = PH_DIGITS;
      end else begin
        base_d   = (st.base == BASE_AUTO) ? BASE_OCT : st.base;
        acc_d    = '0;
        any_d    = 1'b1;
        go_digit = 1'b1;
      end
    end

    if (go_digit) begin
      state_o.base  = base_d;
      state_o.phase = PH_DIGITS;
      if (d < {1'b0, base_d}) begin
        state_o.acc = acc_d * {{(VALUE_W-RADIX_W){1'b0}}, base_d}
                    + {{(VALUE_W-DIGIT_W){1'b0}}, d};
        state_o.any = 1'b1;
      end else begin
        state_o.acc        = acc_d;
        state_o.any        = any_d;
        state_o.phase      = PH_IDLE;
        res_o.valid        = 1'b1;
        res_o.value        = st.neg ? -acc_d : acc_d;
        res_o.end_offset   = any_d ? pos_ext[OFFSET_W-1:0] : '0;
        res_o.digits_found = any_d;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/radix_text_to_integer_parser_top.sv =====
`default_nettype none
// Streaming text-to-integer parser: one character per word on in_if, with first marking
// the start of a string and carrying the radix (0 auto-detects 0x / 0 / decimal). One
// result word leaves on out_if when the first non-digit character (NUL included) arrives;
// later characters are dropped until the next first. Throughput is one character per
// clock while out_if is not stalled; a combinational 64x6 multiply-accumulate updates the
// value. Input and result words are registered. Values wrap modulo 2^64, offsets saturate.
module radix_text_to_integer_parser_top (
  input  logic clk,
  input  logic rst_n,
  rtip_in_if.sink    in_if,
  rtip_out_if.source out_if
);
  import rtip_pkg::*;

  logic               in_vld_r;
  logic [CH_W-1:0]    in_ch_r;
  logic               in_first_r;
  logic [RADIX_W-1:0] in_radix_r;

  rtip_state_t state_r;
  rtip_state_t state_nxt;
  rtip_res_t   res_nxt;

  logic                      out_vld_r;
  logic signed [VALUE_W-1:0] out_value_r;
  logic [OFFSET_W-1:0]       out_offset_r;
  logic                      out_found_r;

  logic adv;

  assign adv         = in_vld_r && (!out_vld_r || out_if.ready);
  assign in_if.ready = !in_vld_r || adv;

  rtip_step u_step (
    .state_i (state_r),
    .ch_i    (in_ch_r),
    .first_i (in_first_r),
    .radix_i (in_radix_r),
    .state_o (state_nxt),
    .res_o   (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_if.valid && in_if.ready) begin
      in_vld_r <= 1'b1;
    end else if (adv) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      in_ch_r    <= in_if.ch;
      in_first_r <= in_if.first;
      in_radix_r <= in_if.radix;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '{phase: PH_IDLE, acc: '0, neg: 1'b0, base: '0, pos: '0, any: 1'b0};
    end else if (adv) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv && res_nxt.valid) begin
      out_vld_r <= 1'b1;
    end else if (out_if.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res_nxt.valid) begin
      out_value_r  <= res_nxt.value;
      out_offset_r <= res_nxt.end_offset;
      out_found_r  <= res_nxt.digits_found;
    end
  end

  assign out_if.valid        = out_vld_r;
  assign out_if.value        = out_value_r;
  assign out_if.end_offset   = out_offset_r;
  assign out_if.digits_found = out_found_r;

`ifndef SYNTHESIS
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> state_r.phase == PH_IDLE)
    else $error("parser not idle after reset");

  a_result_ends_parse: assert property (@(posedge clk) disable iff (!rst_n)
    adv && res_nxt.valid |=> state_r.phase == PH_IDLE && out_vld_r)
    else $error("result word did not end the parse");

  a_no_digits_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_found_r |-> out_value_r == '0 && out_offset_r == '0)
    else $error("result without digits is not zero");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_vld_r |-> in_if.ready)
    else $error("input stage empty but not ready");
`endif

endmodule
`default_nettype wire
